### sv/nearest_center_merge_table_core_macros.svh
// Assertion macros shared by the nearest center merge table core.
`ifndef NEAREST_CENTER_MERGE_TABLE_CORE_MACROS_SVH
`define NEAREST_CENTER_MERGE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define NCMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ncmt check failed");

// Next-cycle implication, checked outside reset
`define NCMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncmt check failed");

`endif

### sv/ncmt_pkg.sv
// Shared types and constants of the nearest center merge table.
package ncmt_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_CENTERS_DEF = 16;
    localparam int COORD_BITS_DEF  = 24;

    // Fixed widths
    localparam int DIST_BITS = 50;
    localparam int IDXW      = 8;   // index field width in the control struct
    localparam int CNTW      = 9;   // count field width in the control struct

    // Commands
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_QUERY  = 3'd2;
    localparam logic [2:0] CMD_MERGE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOCAND = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    // Write data select
    localparam logic [1:0] WR_APPEND = 2'd0;
    localparam logic [1:0] WR_HALF   = 2'd1;
    localparam logic [1:0] WR_COPY   = 2'd2;

    // Result field sources
    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_QUERY = 2'd1;
    localparam logic [1:0] RES_READ  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic            in_ld;
        logic            ref_ld_mem;
        logic            scan_start;
        logic            rd_en;
        logic [IDXW-1:0] rd_addr;
        logic            scan_valid;
        logic            wr_en;
        logic [IDXW-1:0] wr_addr;
        logic [1:0]      wr_sel;
        logic            res_load;
        logic [1:0]      res_kind;
        logic [1:0]      res_status;
        logic [CNTW-1:0] res_count;
    } dp_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic            pipe_busy;
        logic            found;
        logic            merge_hit;
        logic            ref_ne;
        logic [IDXW-1:0] best_idx;
    } dp_sts_t;

endpackage

### sv/ncmt_dp.sv
// Datapath: center memory, distance pipeline, best tracker and result register.
module ncmt_dp #(
    parameter int MAX_CENTERS = ncmt_pkg::MAX_CENTERS_DEF,
    parameter int COORD_BITS  = ncmt_pkg::COORD_BITS_DEF,
    localparam int IW = $clog2(MAX_CENTERS),
    localparam int CW = $clog2(MAX_CENTERS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [COORD_BITS-1:0]      x_in,
    input  logic signed [COORD_BITS-1:0]      y_in,
    input  logic signed [COORD_BITS-1:0]      z_in,
    input  logic [15:0]                       member_count,
    input  logic [15:0]                       average_count,
    input  logic                              cfg_valid,
    input  logic [ncmt_pkg::DIST_BITS-1:0]    cfg_data,
    input  ncmt_pkg::dp_ctl_t                 ctl,
    output ncmt_pkg::dp_sts_t                 sts,
    output logic [1:0]                        status,
    output logic [IW-1:0]                     nearest_index,
    output logic [ncmt_pkg::DIST_BITS-1:0]    dist_sq,
    output logic [CW-1:0]                     center_count,
    output logic signed [COORD_BITS-1:0]      x_out,
    output logic signed [COORD_BITS-1:0]      y_out,
    output logic signed [COORD_BITS-1:0]      z_out
);

    localparam int CB   = COORD_BITS;
    localparam int WW   = 3 * CB + 1;
    localparam int SQW  = 2 * (CB + 1);
    localparam int DW   = SQW + 2;
    localparam int CMPW = (DW > ncmt_pkg::DIST_BITS) ? DW : ncmt_pkg::DIST_BITS;

    // Center memory: {nonempty, z, y, x}
    logic [WW-1:0] mem [MAX_CENTERS];
    logic [WW-1:0] rd_data_reg;
    logic [WW-1:0] wr_data;

    // Reference point and its flag
    logic [CB-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic          ref_ne_reg;

    logic [ncmt_pkg::DIST_BITS-1:0] radius_reg;

    // Pipeline stages
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IW-1:0]        idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [CB:0]   dx_reg, dy_reg, dz_reg;
    logic [SQW-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [DW-1:0]        sum_reg;

    // Best tracker
    logic                 found_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [DW-1:0]        best_d_reg;

    // Result register
    logic [1:0]           status_reg;
    logic [IW-1:0]        nidx_reg;
    logic [ncmt_pkg::DIST_BITS-1:0] dist_reg;
    logic [CW-1:0]        count_reg;
    logic [CB-1:0]        xo_reg, yo_reg, zo_reg;

    // Stored center fields
    logic [CB-1:0] cx, cy, cz;
    logic          cne;
    assign cx  = rd_data_reg[CB-1:0];
    assign cy  = rd_data_reg[2*CB-1:CB];
    assign cz  = rd_data_reg[3*CB-1:2*CB];
    assign cne = rd_data_reg[3*CB];

    // Sign-extended operands
    logic signed [CB:0] ex_r, ey_r, ez_r, ex_c, ey_c, ez_c;
    assign ex_r = $signed({ref_x_reg[CB-1], ref_x_reg});
    assign ey_r = $signed({ref_y_reg[CB-1], ref_y_reg});
    assign ez_r = $signed({ref_z_reg[CB-1], ref_z_reg});
    assign ex_c = $signed({cx[CB-1], cx});
    assign ey_c = $signed({cy[CB-1], cy});
    assign ez_c = $signed({cz[CB-1], cz});

    // Floor of the average: arithmetic shift of the widened sum
    logic signed [CB:0] hx, hy, hz;
    assign hx = (ex_c + ex_r) >>> 1;
    assign hy = (ey_c + ey_r) >>> 1;
    assign hz = (ez_c + ez_r) >>> 1;

    // Write data select
    always_comb
    begin
        unique case (ctl.wr_sel)
            ncmt_pkg::WR_APPEND: wr_data = {ref_ne_reg, ref_z_reg, ref_y_reg, ref_x_reg};
            ncmt_pkg::WR_HALF:   wr_data = {cne, hz[CB-1:0], hy[CB-1:0], hx[CB-1:0]};
            default:             wr_data = rd_data_reg;
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr[IW-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr[IW-1:0]];
        end
    end

    // Reference point
    always_ff @(posedge clk)
    begin
        if (ctl.in_ld)
        begin
            ref_x_reg  <= x_in;
            ref_y_reg  <= y_in;
            ref_z_reg  <= z_in;
            ref_ne_reg <= (member_count != 16'd0) && (average_count != 16'd0);
        end
        else if (ctl.ref_ld_mem)
        begin
            ref_x_reg  <= cx;
            ref_y_reg  <= cy;
            ref_z_reg  <= cz;
            ref_ne_reg <= cne;
        end
    end

    // Merge radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    // Pipeline valid tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd_en && ctl.scan_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Differences, squares, sum
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            idx1_reg <= ctl.rd_addr[IW-1:0];
        end
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        dx_reg   <= ex_r - ex_c;
        dy_reg   <= ey_r - ey_c;
        dz_reg   <= ez_r - ez_c;
        sqx_reg  <= SQW'(dx_reg * dx_reg);
        sqy_reg  <= SQW'(dy_reg * dy_reg);
        sqz_reg  <= SQW'(dz_reg * dz_reg);
        sum_reg  <= DW'(sqx_reg) + DW'(sqy_reg) + DW'(sqz_reg);
    end

    // Best tracker: strict less keeps the lowest index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.scan_start)
        begin
            found_reg <= 1'b0;
        end
        else if (v4_reg && (!found_reg || (sum_reg < best_d_reg)))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.scan_start && v4_reg && (!found_reg || (sum_reg < best_d_reg)))
        begin
            best_idx_reg <= idx4_reg;
            best_d_reg   <= sum_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            status_reg <= ctl.res_status;
            count_reg  <= ctl.res_count[CW-1:0];
            if (ctl.res_kind == ncmt_pkg::RES_QUERY)
            begin
                nidx_reg <= best_idx_reg;
                dist_reg <= ncmt_pkg::DIST_BITS'(best_d_reg);
            end
            else
            begin
                nidx_reg <= '0;
                dist_reg <= '0;
            end
            if (ctl.res_kind == ncmt_pkg::RES_READ)
            begin
                xo_reg <= cx;
                yo_reg <= cy;
                zo_reg <= cz;
            end
            else
            begin
                xo_reg <= '0;
                yo_reg <= '0;
                zo_reg <= '0;
            end
        end
    end

    // Status to the controller
    assign sts.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign sts.found     = found_reg;
    assign sts.merge_hit = found_reg && (CMPW'(best_d_reg) <= CMPW'(radius_reg));
    assign sts.ref_ne    = ref_ne_reg;
    assign sts.best_idx  = ncmt_pkg::IDXW'(best_idx_reg);

    assign status        = status_reg;
    assign nearest_index = nidx_reg;
    assign dist_sq       = dist_reg;
    assign center_count  = count_reg;
    assign x_out         = xo_reg;
    assign y_out         = yo_reg;
    assign z_out         = zo_reg;

endmodule

### sv/ncmt_ctrl.sv
// Controller: command sequencer, table count and output handshake.
module ncmt_ctrl #(
    parameter int MAX_CENTERS = ncmt_pkg::MAX_CENTERS_DEF,
    localparam int IW = $clog2(MAX_CENTERS),
    localparam int CW = $clog2(MAX_CENTERS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic [2:0]        cmd,
    input  logic [IW:0]       skip_index,
    input  logic [IW-1:0]     read_index,
    output ncmt_pkg::dp_ctl_t ctl,
    input  ncmt_pkg::dp_sts_t sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_APPEND   = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_DRAIN    = 4'd3;
    localparam logic [3:0] S_M_RD_I   = 4'd4;
    localparam logic [3:0] S_M_LD_I   = 4'd5;
    localparam logic [3:0] S_M_DECIDE = 4'd6;
    localparam logic [3:0] S_M_RD_P   = 4'd7;
    localparam logic [3:0] S_M_WR_P   = 4'd8;
    localparam logic [3:0] S_REMOVE   = 4'd9;
    localparam logic [3:0] S_C_RD     = 4'd10;
    localparam logic [3:0] S_C_WR     = 4'd11;
    localparam logic [3:0] S_M_NEXT   = 4'd12;
    localparam logic [3:0] S_RD       = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic          skip_en_reg, skip_en_next;
    logic [IW-1:0] skip_idx_reg, skip_idx_next;
    logic [IW-1:0] ridx_reg, ridx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [1:0]    status_reg, status_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] k_plus;

    assign k_plus = CW'(k_reg) + CW'(1);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        skip_en_next   = skip_en_reg;
        skip_idx_next  = skip_idx_reg;
        ridx_next      = ridx_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        ctl.res_count  = ncmt_pkg::CNTW'(count_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.in_ld     = 1'b1;
                    cmd_next      = cmd;
                    ridx_next     = read_index;
                    skip_en_next  = !skip_index[IW];
                    skip_idx_next = skip_index[IW-1:0];
                    status_next   = ncmt_pkg::ST_OK;
                    state_next    = S_FINISH;
                    unique case (cmd)
                        ncmt_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ncmt_pkg::CMD_APPEND:
                        begin
                            if (count_reg == CW'(MAX_CENTERS))
                                status_next = ncmt_pkg::ST_FULL;
                            else
                                state_next = S_APPEND;
                        end
                        ncmt_pkg::CMD_QUERY:
                        begin
                            ctl.scan_start = 1'b1;
                            j_next         = '0;
                            state_next     = S_SCAN;
                        end
                        ncmt_pkg::CMD_MERGE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                i_next     = IW'(count_reg - CW'(1));
                                state_next = S_M_RD_I;
                            end
                        end
                        ncmt_pkg::CMD_READ:
                        begin
                            if (CW'(read_index) < count_reg)
                                state_next = S_RD;
                            else
                                status_next = ncmt_pkg::ST_RANGE;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = ncmt_pkg::IDXW'(count_reg[IW-1:0]);
                ctl.wr_sel  = ncmt_pkg::WR_APPEND;
                count_next  = count_reg + CW'(1);
                state_next  = S_FINISH;
            end
            S_SCAN:
            begin
                // one stored center issued per cycle
                if (j_reg < count_reg)
                begin
                    ctl.rd_en      = 1'b1;
                    ctl.rd_addr    = ncmt_pkg::IDXW'(j_reg[IW-1:0]);
                    ctl.scan_valid = !(skip_en_reg && (j_reg[IW-1:0] == skip_idx_reg));
                    j_next         = j_reg + CW'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = (cmd_reg == ncmt_pkg::CMD_MERGE) ? S_M_DECIDE : S_FINISH;
            end
            S_M_RD_I:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = ncmt_pkg::IDXW'(i_reg);
                state_next  = S_M_LD_I;
            end
            S_M_LD_I:
            begin
                ctl.ref_ld_mem = 1'b1;
                ctl.scan_start = 1'b1;
                j_next         = '0;
                skip_en_next   = 1'b1;
                skip_idx_next  = i_reg;
                state_next     = S_SCAN;
            end
            S_M_DECIDE:
            begin
                k_next = i_reg;
                priority if (sts.merge_hit)
                    state_next = S_M_RD_P;
                else if (!sts.ref_ne)
                    state_next = S_REMOVE;
                else
                    state_next = S_M_NEXT;
            end
            S_M_RD_P:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = sts.best_idx;
                state_next  = S_M_WR_P;
            end
            S_M_WR_P:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = sts.best_idx;
                ctl.wr_sel  = ncmt_pkg::WR_HALF;
                state_next  = S_REMOVE;
            end
            S_REMOVE:
            begin
                // shift higher entries down one place
                if (k_plus < count_reg)
                begin
                    state_next = S_C_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_M_NEXT;
                end
            end
            S_C_RD:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = ncmt_pkg::IDXW'(k_plus);
                state_next  = S_C_WR;
            end
            S_C_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = ncmt_pkg::IDXW'(k_reg);
                ctl.wr_sel  = ncmt_pkg::WR_COPY;
                k_next      = IW'(k_plus);
                state_next  = S_REMOVE;
            end
            S_M_NEXT:
            begin
                if (i_reg == IW'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    i_next     = i_reg - IW'(1);
                    state_next = S_M_RD_I;
                end
            end
            S_RD:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = ncmt_pkg::IDXW'(ridx_reg);
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (cmd_reg == ncmt_pkg::CMD_QUERY)
                begin
                    ctl.res_status = sts.found ? ncmt_pkg::ST_OK : ncmt_pkg::ST_NOCAND;
                    ctl.res_kind   = sts.found ? ncmt_pkg::RES_QUERY : ncmt_pkg::RES_NONE;
                end
                else
                begin
                    ctl.res_status = status_reg;
                    ctl.res_kind   = ((cmd_reg == ncmt_pkg::CMD_READ) &&
                                      (status_reg == ncmt_pkg::ST_OK)) ?
                                     ncmt_pkg::RES_READ : ncmt_pkg::RES_NONE;
                end
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-command working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        skip_en_reg  <= skip_en_next;
        skip_idx_reg <= skip_idx_next;
        ridx_reg     <= ridx_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### sv/nearest_center_merge_table_core.sv
// Top level of the nearest center merge table.
// Holds up to MAX_CENTERS 3-D centers in a memory with one write and one read
// port and answers one result item per command item. A nearest query sweeps
// the stored centers one per cycle through a four-stage distance pipeline. A
// merge pass visits each center from the last down to index 1, scans the
// others for its nearest one, averages it into that one when within the merge
// radius and removes it when merged or when empty, moving the higher entries
// down one place. New items are taken while a finished result still waits in
// the output register.
`include "nearest_center_merge_table_core_macros.svh"

module nearest_center_merge_table_core #(
    parameter int MAX_CENTERS = ncmt_pkg::MAX_CENTERS_DEF,
    parameter int COORD_BITS  = ncmt_pkg::COORD_BITS_DEF,
    localparam int IW = $clog2(MAX_CENTERS),
    localparam int CW = $clog2(MAX_CENTERS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic signed [COORD_BITS-1:0]   x_in,
    input  logic signed [COORD_BITS-1:0]   y_in,
    input  logic signed [COORD_BITS-1:0]   z_in,
    input  logic signed [IW:0]             skip_index,
    input  logic [IW-1:0]                  read_index,
    input  logic [15:0]                    member_count,
    input  logic [15:0]                    average_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [IW-1:0]                  nearest_index,
    output logic [ncmt_pkg::DIST_BITS-1:0] dist_sq,
    output logic [CW-1:0]                  center_count,
    output logic signed [COORD_BITS-1:0]   x_out,
    output logic signed [COORD_BITS-1:0]   y_out,
    output logic signed [COORD_BITS-1:0]   z_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ncmt_pkg::DIST_BITS-1:0] cfg_data
);

    ncmt_pkg::dp_ctl_t ctl;
    ncmt_pkg::dp_sts_t sts;

    // Radius register takes a write in any cycle
    assign cfg_ready = 1'b1;

    ncmt_ctrl #(
        .MAX_CENTERS (MAX_CENTERS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .skip_index (skip_index),
        .read_index (read_index),
        .ctl        (ctl),
        .sts        (sts)
    );

    ncmt_dp #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .x_in          (x_in),
        .y_in          (y_in),
        .z_in          (z_in),
        .member_count  (member_count),
        .average_count (average_count),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .ctl           (ctl),
        .sts           (sts),
        .status        (status),
        .nearest_index (nearest_index),
        .dist_sq       (dist_sq),
        .center_count  (center_count),
        .x_out         (x_out),
        .y_out         (y_out),
        .z_out         (z_out)
    );

    // Checks
    `NCMT_ASSERT_NOW(a_count_max, out_valid, center_count <= CW'(MAX_CENTERS))
    `NCMT_ASSERT_NOW(a_full_count, out_valid && (status == ncmt_pkg::ST_FULL), center_count == CW'(MAX_CENTERS))
    `NCMT_ASSERT_NOW(a_nocand_zero, out_valid && (status == ncmt_pkg::ST_NOCAND), (dist_sq == '0) && (nearest_index == '0))
    `NCMT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

### tb/nearest_center_merge_table_core_test.sv
// Self-checking testbench for the nearest center merge table core.
`timescale 1ns / 100ps

module nearest_center_merge_table_core_test;

    localparam int NC = 16;
    localparam int CB = 24;

    // One command item
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic signed [4:0]  skip;
        logic [3:0]         ridx;
        logic [15:0]        mc;
        logic [15:0]        ac;
    } cmd_item_t;

    // One result item
    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         nidx;
        logic [49:0]        dist_val;
        logic [4:0]         count;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] cmd = '0;
    logic signed [23:0] x_in = '0, y_in = '0, z_in = '0;
    logic signed [4:0] skip_index = '0;
    logic [3:0] read_index = '0;
    logic [15:0] member_count = '0, average_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [3:0] nearest_index;
    logic [49:0] dist_sq;
    logic [4:0] center_count;
    logic signed [23:0] x_out, y_out, z_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [49:0] cfg_data = '0;

    nearest_center_merge_table_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .x_in(x_in), .y_in(y_in), .z_in(z_in),
        .skip_index(skip_index), .read_index(read_index),
        .member_count(member_count), .average_count(average_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .nearest_index(nearest_index), .dist_sq(dist_sq),
        .center_count(center_count), .x_out(x_out), .y_out(y_out), .z_out(z_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic signed [23:0] tab_x [NC];
    logic signed [23:0] tab_y [NC];
    logic signed [23:0] tab_z [NC];
    logic               tab_ne [NC];
    int                 tab_n;
    logic [49:0]        radius_sq;

    cmd_item_t pending_items[$];
    answer_t   expected_answers[$];
    int  mismatches = 0;
    bit  send_pause = 0;
    bit  hold_rx = 0;
    int  hold_cycles = 0;

    function automatic logic [49:0] sq_dist(logic signed [23:0] ax, logic signed [23:0] ay,
                                            logic signed [23:0] az, int k);
        logic signed [25:0] dx, dy, dz;
        logic [49:0] s;
        dx = 26'(ax) - 26'(tab_x[k]);
        dy = 26'(ay) - 26'(tab_y[k]);
        dz = 26'(az) - 26'(tab_z[k]);
        s = 50'(dx * dx) + 50'(dy * dy) + 50'(dz * dz);
        return s;
    endfunction

    // Lowest-index strictly nearest center; returns 0 when none
    function automatic bit nearest(logic signed [23:0] ax, logic signed [23:0] ay,
                                   logic signed [23:0] az, int skip,
                                   output int best, output logic [49:0] bd);
        bit found;
        logic [49:0] r;
        found = 0;
        best = 0;
        bd = '0;
        for (int k = 0; k < tab_n; k++)
        begin
            if (k == skip) continue;
            r = sq_dist(ax, ay, az, k);
            if (!found || r < bd)
            begin
                found = 1;
                best = k;
                bd = r;
            end
        end
        return found;
    endfunction

    function automatic logic signed [23:0] avg2(logic signed [23:0] a, logic signed [23:0] b);
        logic signed [24:0] s;
        s = 25'(a) + 25'(b);
        return s[24:1];
    endfunction

    function automatic void drop_entry(int k);
        for (int j = k; j + 1 < tab_n; j++)
        begin
            tab_x[j] = tab_x[j+1];
            tab_y[j] = tab_y[j+1];
            tab_z[j] = tab_z[j+1];
            tab_ne[j] = tab_ne[j+1];
        end
        tab_n--;
    endfunction

    function automatic answer_t predict_answer(cmd_item_t it);
        answer_t a;
        int p, skip;
        logic [49:0] d;
        a = '0;
        skip = int'(it.skip);
        if (skip < -1) skip = -1;
        case (it.cmd)
            ncmt_pkg::CMD_CLEAR: tab_n = 0;
            ncmt_pkg::CMD_APPEND:
                if (tab_n >= NC) a.status = ncmt_pkg::ST_FULL;
                else
                begin
                    tab_x[tab_n] = it.x;
                    tab_y[tab_n] = it.y;
                    tab_z[tab_n] = it.z;
                    tab_ne[tab_n] = (it.mc != 0) && (it.ac != 0);
                    tab_n++;
                end
            ncmt_pkg::CMD_QUERY:
                if (nearest(it.x, it.y, it.z, skip, p, d))
                begin
                    a.nidx = p[3:0];
                    a.dist_val = d;
                end
                else a.status = ncmt_pkg::ST_NOCAND;
            ncmt_pkg::CMD_MERGE:
                for (int i = tab_n - 1; i >= 1; i--)
                begin
                    if (nearest(tab_x[i], tab_y[i], tab_z[i], i, p, d) && d <= radius_sq)
                    begin
                        tab_x[p] = avg2(tab_x[p], tab_x[i]);
                        tab_y[p] = avg2(tab_y[p], tab_y[i]);
                        tab_z[p] = avg2(tab_z[p], tab_z[i]);
                        drop_entry(i);
                    end
                    else if (!tab_ne[i]) drop_entry(i);
                end
            ncmt_pkg::CMD_READ:
                if (int'(it.ridx) >= tab_n) a.status = ncmt_pkg::ST_RANGE;
                else
                begin
                    a.x = tab_x[it.ridx];
                    a.y = tab_y[it.ridx];
                    a.z = tab_z[it.ridx];
                end
            default: ;
        endcase
        a.count = tab_n[4:0];
        return a;
    endfunction

    // Driver: bursts and gaps, holds payload while stalled
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_answers.push_back(predict_answer(pending_items.pop_front()));
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                if (pending_items.size() > 0 && !send_pause && gap_left == 0)
                begin
                    cmd <= pending_items[0].cmd;
                    x_in <= pending_items[0].x;
                    y_in <= pending_items[0].y;
                    z_in <= pending_items[0].z;
                    skip_index <= pending_items[0].skip;
                    read_index <= pending_items[0].ridx;
                    member_count <= pending_items[0].mc;
                    average_count <= pending_items[0].ac;
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_rx)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            hold_cycles <= 0;
            out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, nearest_index, dist_sq, center_count, x_out, y_out, z_out};
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    function automatic cmd_item_t make_item(logic [2:0] c);
        cmd_item_t it;
        it.cmd = c;
        it.x = 24'($urandom);
        it.y = 24'($urandom);
        it.z = 24'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            // clustered points so merges happen
            it.x = 24'(int'($signed(10'($urandom))) + 1000 * int'($urandom_range(0, 3)));
            it.y = $signed(10'($urandom));
            it.z = $signed(10'($urandom));
        end
        it.skip = 5'($urandom);
        it.ridx = 4'($urandom);
        it.mc = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        it.ac = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        return it;
    endfunction

    function automatic logic [2:0] random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return ncmt_pkg::CMD_APPEND;
        if (r < 65) return ncmt_pkg::CMD_QUERY;
        if (r < 80) return ncmt_pkg::CMD_READ;
        if (r < 88) return ncmt_pkg::CMD_MERGE;
        if (r < 94) return ncmt_pkg::CMD_CLEAR;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_radius(logic [49:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        radius_sq = v;
    endtask

    // Stimulus
    initial
    begin
        cmd_item_t it;
        logic [49:0] radii [4];
        tab_n = 0;
        radius_sq = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, extremes, full table, range cases
        it = make_item(ncmt_pkg::CMD_QUERY); it.skip = -5'sd1; pending_items.push_back(it);
        it = make_item(ncmt_pkg::CMD_READ); it.ridx = 4'd0; pending_items.push_back(it);
        it = make_item(ncmt_pkg::CMD_APPEND);
        it.x = 24'h7FFFFF; it.y = 24'h7FFFFF; it.z = 24'h7FFFFF;
        it.mc = 16'hFFFF; it.ac = 16'hFFFF; pending_items.push_back(it);
        it = make_item(ncmt_pkg::CMD_QUERY); it.skip = 5'sd0; pending_items.push_back(it);
        it = make_item(ncmt_pkg::CMD_QUERY);
        it.x = 24'h800000; it.y = 24'h800000; it.z = 24'h800000;
        it.skip = -5'sd16; pending_items.push_back(it);
        it = make_item(ncmt_pkg::CMD_APPEND);
        it.x = 24'h800000; it.y = 24'h800000; it.z = 24'h800000;
        it.mc = 16'd0; it.ac = 16'd0; pending_items.push_back(it);
        for (int k = 0; k < 15; k++)
            pending_items.push_back(make_item(ncmt_pkg::CMD_APPEND));
        it = make_item(ncmt_pkg::CMD_READ); it.ridx = 4'd15; pending_items.push_back(it);
        it = make_item(ncmt_pkg::CMD_QUERY); it.skip = 5'sd15; pending_items.push_back(it);
        it = make_item(3'd7); pending_items.push_back(it);
        pending_items.push_back(make_item(ncmt_pkg::CMD_MERGE));
        it = make_item(ncmt_pkg::CMD_CLEAR); pending_items.push_back(it);
        wait_drained();

        // Random phases over several radius settings
        radii[0] = '0;
        radii[1] = 50'h3FFFFFFFFFFFF;
        radii[2] = 50'd200000;
        radii[3] = 50'($urandom);
        for (int ph = 0; ph < 8; ph++)
        begin
            write_radius(radii[ph % 4]);
            for (int n = 0; n < 250; n++)
                pending_items.push_back(make_item(random_cmd()));
            if (ph == 2)
            begin
                // long receiver hold while the sender keeps offering
                hold_rx = 1;
                while (hold_cycles < 3000) @(posedge clk);
                hold_rx = 0;
            end
            if (ph == 5)
            begin
                // sender pause until all results are in
                while (pending_items.size() > 125) @(posedge clk);
                send_pause = 1;
                @(posedge clk);
                while (in_valid || expected_answers.size() != 0) @(posedge clk);
                send_pause = 0;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Timeout
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/ncmt_pkg.sv
sv/ncmt_dp.sv
sv/ncmt_ctrl.sv
sv/nearest_center_merge_table_core.sv
tb/nearest_center_merge_table_core_test.sv
